[design/snm_pkg.sv]
// Shared types, constants and tap tables of the Sobel normal-map block.
`timescale 1ns / 1ps
`default_nettype none
package snm_pkg;

   localparam int IMG_WIDTH_BITS   = 11;
   localparam int IMG_HEIGHT_BITS  = 16;
   localparam int RESET_WIDTH      = 256;
   localparam int RESET_HEIGHT     = 256;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;
   localparam int QUEUE_DEPTH_BITS = 2;
   localparam int HEIGHT_IN_BITS   = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_DRAIN  = 1'b1;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
   localparam logic [15:0] CHAN_SCALE_SQ = 16'd65025;

   typedef struct packed {
      logic                      req_type;
      logic [HEIGHT_IN_BITS-1:0] height_sample;
   } snm_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_of_frame;
   } snm_rsp_type;

   typedef struct packed {
      logic up;
      logic down;
      logic left;
      logic right;
      logic last;
   } snm_edge_type;

   typedef enum logic [1:0] {
      OFF_MINUS,
      OFF_ZERO,
      OFF_PLUS
   } snm_offset_type;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } snm_chan_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_FETCH,
      BK_SQX,
      BK_SQY,
      BK_ASQ,
      BK_RLO,
      BK_RHI,
      BK_TSQ,
      BK_LLO,
      BK_LHI,
      BK_CMP,
      BK_OUT
   } snm_back_state_type;

   // Taps in order: top-left, top, top-right, left, right, bottom-left, bottom, bottom-right.
   function automatic snm_offset_type tap_row(input logic [2:0] k);
      snm_offset_type r;
      case (k)
         3'd0, 3'd1, 3'd2: r = OFF_MINUS;
         3'd3, 3'd4:       r = OFF_ZERO;
         default:          r = OFF_PLUS;
      endcase
      return r;
   endfunction

   function automatic snm_offset_type tap_col(input logic [2:0] k);
      snm_offset_type c;
      case (k)
         3'd0, 3'd3, 3'd5: c = OFF_MINUS;
         3'd1, 3'd6:       c = OFF_ZERO;
         default:          c = OFF_PLUS;
      endcase
      return c;
   endfunction

   function automatic logic signed [2:0] tap_dx(input logic [2:0] k);
      logic signed [2:0] w;
      case (k)
         3'd0, 3'd5: w = -3'sd1;
         3'd2, 3'd7: w = 3'sd1;
         3'd3:       w = -3'sd2;
         3'd4:       w = 3'sd2;
         default:    w = 3'sd0;
      endcase
      return w;
   endfunction

   function automatic logic signed [2:0] tap_dy(input logic [2:0] k);
      logic signed [2:0] w;
      case (k)
         3'd0, 3'd2: w = -3'sd1;
         3'd5, 3'd7: w = 3'sd1;
         3'd1:       w = -3'sd2;
         3'd6:       w = 3'sd2;
         default:    w = 3'sd0;
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

[design/snm_queue.sv]
// Small job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module snm_queue #(
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 full,
   output logic                 empty
);
   import snm_pkg::*;

   localparam int QB    = QUEUE_DEPTH_BITS;
   localparam int DEPTH = 2 ** QB;

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [DATA_BITS-1:0] entry_in [DEPTH];
   logic [QB-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QB:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == (QB+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         entry_in[wr_ptr_ff] = push_data;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[design/snm_front.sv]
// Front part: takes beats, writes the sample history and decides which pixel is due.
`timescale 1ns / 1ps
`default_nettype none
module snm_front #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  snm_pkg::snm_req_type                    req_data,
   input  logic                                    csr_we,
   input  logic [snm_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [snm_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                    queue_full,
   input  logic                                    work_pending,
   output logic                                    job_push,
   output logic [$clog2(2*MAX_WIDTH+9)-1:0]        job_ptr,
   output snm_pkg::snm_edge_type                   job_edge,
   output logic                                    wr_en,
   output logic [$clog2(2*MAX_WIDTH+9)-1:0]        wr_addr,
   output logic [SAMPLE_BITS-1:0]                  wr_data,
   output logic [$clog2(MAX_WIDTH+1)-1:0]          width_eff
);
   import snm_pkg::*;

   localparam int W_BITS = $clog2(MAX_WIDTH+1);
   localparam int C_BITS = $clog2(MAX_WIDTH);
   localparam int P_BITS = $clog2(MAX_WIDTH+3);
   localparam int H_BITS = $clog2(2*MAX_WIDTH+9);
   localparam int CW     = W_BITS + 2;

   logic [IMG_WIDTH_BITS-1:0]  width_reg_ff, width_reg_in;
   logic [IMG_HEIGHT_BITS-1:0] height_reg_ff, height_reg_in;
   logic [C_BITS-1:0]          out_col_ff, out_col_in;
   logic [IMG_HEIGHT_BITS-1:0] out_row_ff, out_row_in;
   logic [P_BITS-1:0]          pend_ff, pend_in;
   logic [H_BITS-1:0]          newest_ff, newest_in;

   logic [IMG_HEIGHT_BITS-1:0] h_eff;
   logic [CW-1:0]              w_c, d_c, col_c;
   logic [P_BITS-1:0]          pend_nx, d;
   logic [H_BITS-1:0]          newest_nx;
   logic                       is_sample, accept, ready, emit, cfg_hit;
   logic                       last_row, next_last_row, last_col;

   always_comb begin
      if (width_reg_ff == '0) begin
         width_eff = W_BITS'(1);
      end else if (32'(width_reg_ff) > 32'(MAX_WIDTH)) begin
         width_eff = W_BITS'(MAX_WIDTH);
      end else begin
         width_eff = W_BITS'(width_reg_ff);
      end
   end

   assign h_eff     = (height_reg_ff == '0) ? IMG_HEIGHT_BITS'(1) : height_reg_ff;
   assign is_sample = (req_data.req_type == REQ_SAMPLE);
   assign req_stall = queue_full || (pend_ff == '0 && work_pending && is_sample);
   assign accept    = req_valid && !req_stall;
   assign cfg_hit   = csr_we && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   assign pend_nx   = pend_ff + P_BITS'(is_sample);
   assign d         = pend_nx - P_BITS'(1);
   assign newest_nx = newest_ff + H_BITS'(is_sample);

   assign w_c   = CW'(width_eff);
   assign d_c   = CW'(d);
   assign col_c = CW'(out_col_ff);

   assign last_row      = (out_row_ff == h_eff - IMG_HEIGHT_BITS'(1));
   assign next_last_row = (out_row_ff == h_eff - IMG_HEIGHT_BITS'(2));
   assign last_col      = (col_c == w_c - CW'(1));

   // A pixel is due once the sample below-right of it is in, or its frame is complete.
   assign ready = (pend_nx != '0) &&
                  ((d_c >= w_c + CW'(1)) ||
                   (last_row && (d_c + col_c >= w_c - CW'(1))) ||
                   (next_last_row && last_col && (d_c >= w_c)));
   assign emit  = accept && ready;

   assign job_push = emit;
   assign job_ptr  = newest_nx - H_BITS'(d);
   assign job_edge = '{up:    (out_row_ff != '0),
                       down:  !last_row,
                       left:  (out_col_ff != '0),
                       right: !last_col,
                       last:  last_row && last_col};

   assign wr_en   = accept && is_sample;
   assign wr_addr = newest_nx;
   assign wr_data = SAMPLE_BITS'(req_data.height_sample);

   always_comb begin
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      pend_in       = pend_ff;
      newest_in     = newest_ff;
      if (cfg_hit) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_reg_in = csr_wdata[IMG_WIDTH_BITS-1:0];
         end else begin
            height_reg_in = csr_wdata[IMG_HEIGHT_BITS-1:0];
         end
         out_col_in = '0;
         out_row_in = '0;
         pend_in    = '0;
      end else if (accept) begin
         newest_in = newest_nx;
         pend_in   = pend_nx - P_BITS'(emit);
         if (emit) begin
            if (last_col) begin
               out_col_in = '0;
               out_row_in = last_row ? '0 : out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= IMG_WIDTH_BITS'(RESET_WIDTH);
         height_reg_ff <= IMG_HEIGHT_BITS'(RESET_HEIGHT);
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         pend_ff       <= '0;
         newest_ff     <= '0;
      end else begin
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         pend_ff       <= pend_in;
         newest_ff     <= newest_in;
      end
   end

endmodule
`default_nettype wire

[design/snm_back.sv]
// Back part: reads the 3x3 taps, forms the gradients and searches each color channel.
`timescale 1ns / 1ps
`default_nettype none
module snm_back #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [$clog2(2*MAX_WIDTH+9)-1:0]   wr_addr,
   input  logic [SAMPLE_BITS-1:0]             wr_data,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
   input  logic                               job_valid,
   input  logic [$clog2(2*MAX_WIDTH+9)-1:0]   job_ptr,
   input  snm_pkg::snm_edge_type              job_edge,
   output logic                               job_pop,
   output logic                               busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output snm_pkg::snm_rsp_type               rsp_data
);
   import snm_pkg::*;

   localparam int H_BITS    = $clog2(2*MAX_WIDTH+9);
   localparam int D_BITS    = SAMPLE_BITS + 3;
   localparam int MAG_BITS  = SAMPLE_BITS + 2;
   localparam int LEN_BITS  = 2*SAMPLE_BITS + 6;
   localparam int HALF      = SAMPLE_BITS + 3;
   localparam int MX        = (MAG_BITS > 16) ? MAG_BITS : 16;
   localparam int PROD_BITS = LEN_BITS + 16;

   localparam logic signed [D_BITS-1:0] DZ    = D_BITS'(1) << (SAMPLE_BITS-1);
   localparam logic [LEN_BITS-1:0]      DZ_SQ = LEN_BITS'(1) << (2*SAMPLE_BITS-2);

   logic [SAMPLE_BITS-1:0] hist_mem [2**H_BITS];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic [H_BITS-1:0]      rd_addr;

   snm_back_state_type        state_ff, state_in;
   logic [H_BITS-1:0]         ptr_ff, ptr_in;
   snm_edge_type              edge_ff, edge_in;
   logic [3:0]                tap_ff, tap_in;
   logic signed [D_BITS-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [LEN_BITS-1:0]       len_ff, len_in, asq_ff, asq_in;
   logic [PROD_BITS-1:0]      rhs_ff, rhs_in, lhs_ff, lhs_in;
   logic [15:0]               tsq_ff, tsq_in;
   logic [7:0]                m_ff, m_in;
   logic [2:0]                bit_ff, bit_in;
   snm_chan_type              ch_ff, ch_in;
   logic [7:0]                red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   snm_rsp_type               rsp_data_ff, rsp_data_in;

   logic [MX-1:0]             mul_x;
   logic [HALF-1:0]           mul_y;
   logic [MX+HALF-1:0]        mul_p;
   logic [2:0]                prev_tap;
   logic signed [D_BITS-1:0]  samp, a_sel;
   logic signed [2:0]         cx, cy;
   logic [7:0]                cand, tmag, m_next;
   logic                      ok;

   function automatic logic [MAG_BITS-1:0] mag_of(input logic signed [D_BITS-1:0] v);
      return (v < 0) ? MAG_BITS'(-v) : MAG_BITS'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
   end

   always_comb begin
      rd_addr = ptr_ff;
      case (tap_row(tap_ff[2:0]))
         OFF_MINUS: if (edge_ff.up) rd_addr = rd_addr - H_BITS'(width_eff);
         OFF_PLUS:  if (edge_ff.down) rd_addr = rd_addr + H_BITS'(width_eff);
         default: ;
      endcase
      case (tap_col(tap_ff[2:0]))
         OFF_MINUS: if (edge_ff.left) rd_addr = rd_addr - H_BITS'(1);
         OFF_PLUS:  if (edge_ff.right) rd_addr = rd_addr + H_BITS'(1);
         default: ;
      endcase
   end

   assign mul_p     = mul_x * mul_y;
   assign prev_tap  = 3'(tap_ff - 4'd1);
   assign samp      = $signed({3'b000, rd_data_ff});
   assign cx        = tap_dx(prev_tap);
   assign cy        = tap_dy(prev_tap);
   assign cand      = m_ff | (8'd1 << bit_ff);
   assign tmag      = cand[7] ? 8'((9'(cand) << 1) - 9'd255) : 8'(9'd255 - (9'(cand) << 1));
   assign busy      = (state_ff != BK_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (ch_ff)
         CH_RED:   a_sel = dx_ff;
         CH_GREEN: a_sel = dy_ff;
         default:  a_sel = DZ;
      endcase
   end

   // A candidate below zero passes unless the component is negative and too large;
   // one at or above zero passes only while the component is not negative and the squared comparison holds.
   assign ok     = !cand[7] ? ((a_sel >= 0) || (lhs_ff >= rhs_ff))
                            : ((a_sel >= 0) && (lhs_ff <= rhs_ff));
   assign m_next = ok ? cand : m_ff;

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      edge_in      = edge_ff;
      tap_in       = tap_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      len_in       = len_ff;
      asq_in       = asq_ff;
      rhs_in       = rhs_ff;
      lhs_in       = lhs_ff;
      tsq_in       = tsq_ff;
      m_in         = m_ff;
      bit_in       = bit_ff;
      ch_in        = ch_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      job_pop      = 1'b0;
      mul_x        = '0;
      mul_y        = '0;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               ptr_in   = job_ptr;
               edge_in  = job_edge;
               tap_in   = '0;
               dx_in    = '0;
               dy_in    = '0;
               state_in = BK_FETCH;
            end
         end
         BK_FETCH: begin
            if (tap_ff != 4'd0) begin
               case (cx)
                  3'sd2:   dx_in = dx_ff + (samp <<< 1);
                  3'sd1:   dx_in = dx_ff + samp;
                  -3'sd1:  dx_in = dx_ff - samp;
                  -3'sd2:  dx_in = dx_ff - (samp <<< 1);
                  default: dx_in = dx_ff;
               endcase
               case (cy)
                  3'sd2:   dy_in = dy_ff + (samp <<< 1);
                  3'sd1:   dy_in = dy_ff + samp;
                  -3'sd1:  dy_in = dy_ff - samp;
                  -3'sd2:  dy_in = dy_ff - (samp <<< 1);
                  default: dy_in = dy_ff;
               endcase
            end
            if (tap_ff == 4'd8) begin
               state_in = BK_SQX;
            end else begin
               tap_in = tap_ff + 4'd1;
            end
         end
         BK_SQX: begin
            mul_x    = MX'(mag_of(dx_ff));
            mul_y    = HALF'(mag_of(dx_ff));
            len_in   = LEN_BITS'(mul_p);
            state_in = BK_SQY;
         end
         BK_SQY: begin
            mul_x    = MX'(mag_of(dy_ff));
            mul_y    = HALF'(mag_of(dy_ff));
            len_in   = len_ff + LEN_BITS'(mul_p) + DZ_SQ;
            ch_in    = CH_RED;
            state_in = BK_ASQ;
         end
         BK_ASQ: begin
            mul_x    = MX'(mag_of(a_sel));
            mul_y    = HALF'(mag_of(a_sel));
            asq_in   = LEN_BITS'(mul_p);
            state_in = BK_RLO;
         end
         BK_RLO: begin
            mul_x    = MX'(CHAN_SCALE_SQ);
            mul_y    = asq_ff[HALF-1:0];
            rhs_in   = PROD_BITS'(mul_p);
            state_in = BK_RHI;
         end
         BK_RHI: begin
            mul_x    = MX'(CHAN_SCALE_SQ);
            mul_y    = asq_ff[LEN_BITS-1:HALF];
            rhs_in   = rhs_ff + (PROD_BITS'(mul_p) << HALF);
            m_in     = '0;
            bit_in   = 3'd7;
            state_in = BK_TSQ;
         end
         BK_TSQ: begin
            mul_x    = MX'(tmag);
            mul_y    = HALF'(tmag);
            tsq_in   = 16'(mul_p);
            state_in = BK_LLO;
         end
         BK_LLO: begin
            mul_x    = MX'(tsq_ff);
            mul_y    = len_ff[HALF-1:0];
            lhs_in   = PROD_BITS'(mul_p);
            state_in = BK_LHI;
         end
         BK_LHI: begin
            mul_x    = MX'(tsq_ff);
            mul_y    = len_ff[LEN_BITS-1:HALF];
            lhs_in   = lhs_ff + (PROD_BITS'(mul_p) << HALF);
            state_in = BK_CMP;
         end
         BK_CMP: begin
            m_in = m_next;
            if (bit_ff == 3'd0) begin
               case (ch_ff)
                  CH_RED:   red_in   = m_next;
                  CH_GREEN: green_in = m_next;
                  default:  blue_in  = m_next;
               endcase
               if (ch_ff == CH_BLUE) begin
                  state_in = BK_OUT;
               end else begin
                  ch_in    = (ch_ff == CH_RED) ? CH_GREEN : CH_BLUE;
                  state_in = BK_ASQ;
               end
            end else begin
               bit_in   = bit_ff - 3'd1;
               state_in = BK_TSQ;
            end
         end
         BK_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{red:           red_ff,
                                green:         green_ff,
                                blue:          blue_ff,
                                alpha:         ALPHA_OPAQUE,
                                last_of_frame: edge_ff.last};
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      edge_ff     <= edge_in;
      tap_ff      <= tap_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      len_ff      <= len_in;
      asq_ff      <= asq_in;
      rhs_ff      <= rhs_in;
      lhs_ff      <= lhs_in;
      tsq_ff      <= tsq_in;
      m_ff        <= m_in;
      bit_ff      <= bit_in;
      ch_ff       <= ch_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire

[design/sobel_normal_map_rgba.sv]
// Top level of the streaming Sobel normal-map generator with RGBA8 output.
`timescale 1ns / 1ps
`default_nettype none
// Height samples enter in raster order and each emitted pixel is the unit normal of
// (dx, dy, 0.5) from a clamped 3x3 Sobel window, mapped to RGBA8 with alpha 255.
// Pixels leave one row plus one pixel behind the samples; drain beats flush the
// final row. The front takes one beat per cycle while the job queue has room and,
// for a sample, while samples are pending or no job is queued or in work. The back
// part handles one pixel at a time: history reads of the taps, then an exact 8-step
// search per color channel on one shared multiplier whose wide products are
// built from low and high halves. The history is a ring of samples with no
// clearing pass; writes to the width or height register restart the frame.
module sobel_normal_map_rgba #(
   parameter int MAX_WIDTH   = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  snm_pkg::snm_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output snm_pkg::snm_rsp_type               rsp_data,
   input  logic                               csr_we,
   input  logic [snm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [snm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import snm_pkg::*;

   localparam int H_BITS   = $clog2(2*MAX_WIDTH+9);
   localparam int W_BITS   = $clog2(MAX_WIDTH+1);
   localparam int JOB_BITS = H_BITS + $bits(snm_edge_type);

   logic                   queue_full, queue_empty, back_busy;
   logic                   job_push, job_pop, wr_en;
   logic [H_BITS-1:0]      job_ptr, wr_addr;
   snm_edge_type           job_edge;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic [W_BITS-1:0]      width_eff;
   logic [JOB_BITS-1:0]    queue_out;

   snm_front #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .work_pending (!queue_empty || back_busy),
      .job_push     (job_push),
      .job_ptr      (job_ptr),
      .job_edge     (job_edge),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .width_eff    (width_eff)
   );

   snm_queue #(
      .DATA_BITS (JOB_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_ptr, job_edge}),
      .pop       (job_pop),
      .pop_data  (queue_out),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   snm_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .width_eff (width_eff),
      .job_valid (!queue_empty),
      .job_ptr   (queue_out[JOB_BITS-1:$bits(snm_edge_type)]),
      .job_edge  (queue_out[$bits(snm_edge_type)-1:0]),
      .job_pop   (job_pop),
      .busy      (back_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[tb/tb_sobel_normal_map_rgba.sv]
// Self-checking testbench for the Sobel normal-map block, with a built-in pixel predictor.
`timescale 1ns / 1ps
module tb_sobel_normal_map_rgba;
   import snm_pkg::*;

   localparam int MAX_W      = 1024;
   localparam int HIST_LEN   = 2 * MAX_W + 3;
   localparam int SETTLE     = 400;
   localparam int CYCLE_CAP  = 3000000;
   localparam int ITEM_GOAL  = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   snm_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   snm_rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   sobel_normal_map_rgba dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   snm_req_type beat_queue[$];
   snm_rsp_type pixel_queue[$];
   int error_count = 0;
   int cycle_count = 0;
   int items_queued = 0;
   bit sender_paused = 1'b0;
   bit beat_taken = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   // Predictor state.
   logic [10:0] cfg_width = 11'(RESET_WIDTH);
   logic [15:0] cfg_height = 16'(RESET_HEIGHT);
   logic [15:0] hist_ring[0:HIST_LEN-1];
   int unsigned ring_head = 0;
   int unsigned pending_px = 0;
   int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;

   initial for (int i = 0; i < HIST_LEN; i++) hist_ring[i] = '0;

   function automatic int unsigned width_eff();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned height_eff();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   function automatic longint neighbor_height(int unsigned d, int unsigned r, int unsigned c,
                                              int dr, int dc, int unsigned w, int unsigned h);
      longint rr, cc, back_dist;
      int unsigned idx;
      rr = longint'(r) + dr;
      cc = longint'(c) + dc;
      if (rr < 0) rr = 0;
      if (rr > longint'(h) - 1) rr = longint'(h) - 1;
      if (cc < 0) cc = 0;
      if (cc > longint'(w) - 1) cc = longint'(w) - 1;
      back_dist = longint'(d) - ((rr - longint'(r)) * longint'(w) + (cc - longint'(c)));
      if (back_dist < 0 || back_dist >= HIST_LEN) return 0;
      idx = ring_head + HIST_LEN - int'(back_dist);
      if (idx >= HIST_LEN) idx -= HIST_LEN;
      return longint'(hist_ring[idx]);
   endfunction

   function automatic logic [7:0] color_level(longint a, logic [127:0] len_sq);
      logic [127:0] mag, rhs, lhs;
      logic [7:0] m;
      int cand, t;
      bit ok;
      mag = (a < 0) ? 128'(-a) : 128'(a);
      rhs = 128'(65025) * mag * mag;
      m = '0;
      for (int b = 7; b >= 0; b--) begin
         cand = int'(m) | (1 << b);
         t = 2 * cand - 255;
         lhs = 128'(t * t) * len_sq;
         if (t < 0) ok = (a >= 0) || (lhs >= rhs);
         else ok = (a >= 0) && (lhs <= rhs);
         if (ok) m = 8'(cand);
      end
      return m;
   endfunction

   task automatic predict_beat(input snm_req_type it);
      int unsigned w, h, d, r, c;
      longint remain, tl, t, tr, l, rt, bl, bt, br, dx, dy, dz;
      logic [127:0] len_sq;
      snm_rsp_type px;
      w = width_eff();
      h = height_eff();
      if (it.req_type == REQ_SAMPLE) begin
         ring_head = (ring_head + 1 >= HIST_LEN) ? 0 : ring_head + 1;
         hist_ring[ring_head] = it.height_sample;
         pending_px++;
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= h) in_row = 0;
         end
      end
      if (pending_px == 0) return;
      d = pending_px - 1;
      r = out_row;
      c = out_col;
      remain = longint'(w) * h - 1 - (longint'(r) * w + c);
      if (!(longint'(d) >= longint'(w) + 1 || longint'(d) >= remain)) return;
      tl = neighbor_height(d, r, c, -1, -1, w, h);
      t  = neighbor_height(d, r, c, -1,  0, w, h);
      tr = neighbor_height(d, r, c, -1,  1, w, h);
      l  = neighbor_height(d, r, c,  0, -1, w, h);
      rt = neighbor_height(d, r, c,  0,  1, w, h);
      bl = neighbor_height(d, r, c,  1, -1, w, h);
      bt = neighbor_height(d, r, c,  1,  0, w, h);
      br = neighbor_height(d, r, c,  1,  1, w, h);
      dx = (tr + 2 * rt + br) - (tl + 2 * l + bl);
      dy = (bl + 2 * bt + br) - (tl + 2 * t + tr);
      dz = 32768;
      len_sq = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
      px.red = color_level(dx, len_sq);
      px.green = color_level(dy, len_sq);
      px.blue = color_level(dz, len_sq);
      px.alpha = ALPHA_OPAQUE;
      px.last_of_frame = (r == h - 1 && c == w - 1);
      pixel_queue.push_back(px);
      pending_px--;
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= h) out_row = 0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Driver: accept at the rising edge, present the next beat at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_beat(req_data);
         void'(beat_queue.pop_front());
         beat_taken <= 1'b1;
      end
   end

   always @(negedge clock) begin
      beat_taken <= 1'b0;
      if (req_valid && !beat_taken) begin
      end else if (beat_queue.size() > 0 && !sender_paused &&
                   ((cycle_count > 30000 && cycle_count < 90000) ||
                    $urandom_range(0, 99) >= 26)) begin
         req_valid <= 1'b1;
         req_data <= beat_queue[0];
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: random stalls, one long hold-off, and a quiet stretch.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && cycle_count > 100000 && pixel_queue.size() > 0 &&
                   beat_queue.size() > 0) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
         rsp_stall <= 1'b1;
      end else if (cycle_count > 30000 && cycle_count < 90000) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 26);
      end
   end

   always @(posedge clock) begin
      snm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected pixel", 1, 0);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.red != want.red) report_mismatch("red", rsp_data.red, want.red);
            if (rsp_data.green != want.green)
               report_mismatch("green", rsp_data.green, want.green);
            if (rsp_data.blue != want.blue) report_mismatch("blue", rsp_data.blue, want.blue);
            if (rsp_data.alpha != want.alpha)
               report_mismatch("alpha", rsp_data.alpha, want.alpha);
            if (rsp_data.last_of_frame != want.last_of_frame)
               report_mismatch("last_of_frame", rsp_data.last_of_frame, want.last_of_frame);
         end
      end
   end

   task automatic wait_quiet();
      while (beat_queue.size() > 0)
         @(posedge clock);
      sender_paused = 1'b1;
      while (pixel_queue.size() > 0 || req_valid)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      sender_paused = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_IMAGE_WIDTH || idx == CSR_IMAGE_HEIGHT) begin
         if (idx == CSR_IMAGE_WIDTH) cfg_width = val[10:0];
         else cfg_height = val;
         pending_px = 0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_height();
      int k;
      k = $urandom_range(0, 9);
      if (k < 2) return 16'h0000;
      if (k < 4) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic queue_beat(input logic kind, input logic [15:0] val);
      snm_req_type it;
      it.req_type = kind;
      it.height_sample = val;
      beat_queue.push_back(it);
      items_queued++;
   endtask

   task automatic run_phase(input logic [15:0] wv, input logic [15:0] hv,
                            input int nsamp, input int ndrain, input int noise);
      wait_quiet();
      write_reg(CSR_IMAGE_WIDTH, wv);
      write_reg(CSR_IMAGE_HEIGHT, hv);
      if ($urandom_range(0, 3) == 0) queue_beat(REQ_DRAIN, 16'($urandom));
      for (int i = 0; i < nsamp; i++) begin
         if ($urandom_range(0, 99) < noise) queue_beat(REQ_DRAIN, 16'($urandom));
         queue_beat(REQ_SAMPLE, pick_height());
      end
      for (int i = 0; i < ndrain; i++) queue_beat(REQ_DRAIN, 16'($urandom));
   endtask

   initial begin
      int w, h, he, frames;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain with nothing pending, then a 3x3 frame of extreme heights.
      wait_quiet();
      queue_beat(REQ_DRAIN, 16'hFFFF);
      wait_quiet();
      write_reg(CSR_IMAGE_WIDTH, 16'd3);
      write_reg(CSR_IMAGE_HEIGHT, 16'd3);
      queue_beat(REQ_DRAIN, 16'h0000);
      queue_beat(REQ_SAMPLE, 16'hFFFF);
      queue_beat(REQ_SAMPLE, 16'h0000);
      queue_beat(REQ_SAMPLE, 16'hFFFF);
      queue_beat(REQ_SAMPLE, 16'h0000);
      queue_beat(REQ_DRAIN, 16'h1234);
      queue_beat(REQ_SAMPLE, 16'hFFFF);
      queue_beat(REQ_SAMPLE, 16'h0000);
      queue_beat(REQ_SAMPLE, 16'hFFFF);
      queue_beat(REQ_SAMPLE, 16'h0000);
      queue_beat(REQ_SAMPLE, 16'hFFFF);
      for (int i = 0; i < 5; i++) queue_beat(REQ_DRAIN, 16'h0000);
      // Zero width and zero height act as one; unused indexes do nothing.
      wait_quiet();
      write_reg(2'd2, 16'hFFFF);
      write_reg(2'd3, 16'h5555);
      run_phase(16'd0, 16'd0, 3, 2, 0);
      run_phase(16'd1, 16'd1, 2, 1, 0);

      while (items_queued < ITEM_GOAL) begin
         frames = $urandom_range(1, 2);
         case ($urandom_range(0, 9))
            0: begin w = 16'($urandom_range(0, 1)); h = $urandom_range(1, 20); end
            1, 2: begin w = $urandom_range(7, 40); h = $urandom_range(1, 4); end
            3: begin w = $urandom_range(2, 5); h = 65535; frames = 0; end
            default: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); end
         endcase
         he = (h == 65535) ? $urandom_range(2, 8) : h;
         run_phase(16'(w | ($urandom_range(0, 31) << 11)), 16'(h),
                   ((w == 0) ? 1 : w) * he * ((frames == 0) ? 1 : frames) -
                   (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0),
                   w + 3, $urandom_range(0, 1) * 8);
      end
      // One frame at the widest row, with width above the limit.
      run_phase(16'hFFFF, 16'd1, MAX_W, 3, 0);
      run_phase(16'd1024, 16'd2, 12, 4, 0);

      wait_quiet();
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
design/snm_pkg.sv
design/snm_queue.sv
design/snm_front.sv
design/snm_back.sv
design/sobel_normal_map_rgba.sv
tb/tb_sobel_normal_map_rgba.sv
